@@ design/mbq_pkg.sv @@
// Shared constants, register codes and coefficient type for the biquad filter.
`timescale 1ns / 1ps
`default_nettype none

package mbq_pkg;

    // Coefficient word width (signed fixed point)
    localparam int COEF_BITS = 32;

    // Configuration port
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;
    localparam int NUM_REGS = 5;

    // Register indexes, byte address = 4 * index
    typedef enum logic [2:0] {
        REG_B0 = 3'd0,
        REG_B1 = 3'd1,
        REG_B2 = 3'd2,
        REG_A1 = 3'd3,
        REG_A2 = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic signed [COEF_BITS-1:0] b0;
        logic signed [COEF_BITS-1:0] b1;
        logic signed [COEF_BITS-1:0] b2;
        logic signed [COEF_BITS-1:0] a1;
        logic signed [COEF_BITS-1:0] a2;
    } t_coefs;

    // Output queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

endpackage

`default_nettype wire

@@ design/multichannel_biquad_iir_filter.sv @@
// Top level of the multichannel direct form I biquad filter.
`timescale 1ns / 1ps
`default_nettype none

// Multichannel biquad, direct form I: y = b0*x + b1*x1 + b2*x2 - a1*y1 - a2*y2 per
// channel, coefficients signed Q3.29 written over the APB port (b0, b1, b2, a1, a2 at
// byte addresses 0, 4, 8, 12, 16; a0 is 1). The exact sum is rounded to nearest, ties
// upward, and saturated to SAMPLE_BITS. Each channel's x1, x2, y1, y2 sit in one entry
// of a history memory with a registered read; a per-entry valid bit cleared by
// reset makes every channel start from zero, so there is no clearing pass. An item
// enters the history read on acceptance, the five multiplies in the next cycle, and the
// sum, rounding and write-back the cycle after that; its result is then written into a
// four-item output queue and offered from there. Throughput is one item per cycle
// while consecutive items use different channels and the output queue has credit; an
// item that follows one of its own channel is held while the earlier one is in the
// multiply stage, as its y1 is not yet written back. Channel numbers of CHANNELS
// or more use the last channel's history; out_chan echoes the channel field as given.
module multichannel_biquad_iir_filter #(
    parameter int CHANNELS       = 2,
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 29
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    // input item channel
    input  wire logic                             i_valid,
    output logic                                  o_ready,
    input  wire logic signed [SAMPLE_BITS-1:0]    i_sample_in,
    input  wire logic                             i_chan,
    // result item channel
    output logic                                  o_valid,
    input  wire logic                             i_ready,
    output logic signed [SAMPLE_BITS-1:0]         o_sample_out,
    output logic                                  o_out_chan,
    // configuration
    input  wire logic                             psel,
    input  wire logic                             penable,
    input  wire logic                             pwrite,
    input  wire logic [mbq_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [mbq_pkg::PDATA_W-1:0]      pwdata,
    output logic      [mbq_pkg::PDATA_W-1:0]      prdata,
    output logic                                  pready
);
    import mbq_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int PW   = COEF_BITS + SAMPLE_BITS;
    localparam int HW   = 4 * SAMPLE_BITS;

    // b0 resets to 1.0 at the coefficient fraction width, the rest to zero
    localparam logic signed [COEF_BITS-1:0] B0_RESET = COEF_BITS'(1) << COEF_FRAC_BITS;

    // ------------------------------------------------------------------
    // Coefficient registers
    // ------------------------------------------------------------------
    t_coefs r_coefs;
    logic   cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coefs.b0 <= B0_RESET;
            r_coefs.b1 <= '0;
            r_coefs.b2 <= '0;
            r_coefs.a1 <= '0;
            r_coefs.a2 <= '0;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_B0:  r_coefs.b0 <= pwdata;
                REG_B1:  r_coefs.b1 <= pwdata;
                REG_B2:  r_coefs.b2 <= pwdata;
                REG_A1:  r_coefs.a1 <= pwdata;
                REG_A2:  r_coefs.a2 <= pwdata;
                default: ; // beyond the register list: ignored
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_B0:  prdata = r_coefs.b0;
            REG_B1:  prdata = r_coefs.b1;
            REG_B2:  prdata = r_coefs.b2;
            REG_A1:  prdata = r_coefs.a1;
            REG_A2:  prdata = r_coefs.a2;
            default: prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Acceptance: credit for the output queue, interlock on the channel
    // ------------------------------------------------------------------
    logic                  r_a_valid;
    logic                  r_b_valid;
    logic [OUT_CNT_W-1:0]  r_cnt;      // items accepted and not yet delivered
    logic [OUT_CNT_W-1:0]  n_cnt;
    logic [CH_W-1:0]       ch_in;
    logic [CH_W-1:0]       r_a_ch;
    logic                  hazard;
    logic                  acc;
    logic                  pop;

    assign ch_in  = (32'(i_chan) >= CHANNELS) ? CH_W'(CHANNELS - 1) : CH_W'(i_chan);
    // the item in the multiply stage has not written y yet: hold a same-channel item
    assign hazard = r_a_valid && (r_a_ch == ch_in);
    assign o_ready = (r_cnt < OUT_CNT_W'(OUT_DEPTH)) && !hazard;
    assign acc    = i_valid && o_ready;
    assign pop    = o_valid && i_ready;
    assign n_cnt  = r_cnt + OUT_CNT_W'(acc) - OUT_CNT_W'(pop);

    // ------------------------------------------------------------------
    // History memory: {x1, x2, y1, y2} per channel, valid bits for reset
    // ------------------------------------------------------------------
    logic [HW-1:0]          r_hist_mem [CHANNELS];
    logic [CHANNELS-1:0]    r_hist_vld;
    logic [HW-1:0]          r_rd_data;
    logic                   r_rd_vld;
    logic [HW-1:0]          wb_data;
    logic [CH_W-1:0]        r_b_ch;

    // last write, forwarded to a read issued at the edge of that write
    logic                   r_w_valid;
    logic [CH_W-1:0]        r_w_ch;
    logic [HW-1:0]          r_w_data;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_rd_data <= r_hist_mem[ch_in];
            r_rd_vld  <= r_hist_vld[ch_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_hist_mem[r_b_ch] <= wb_data;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: operand select; stage B: products
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] r_a_x;
    logic                          r_a_chan;
    logic [HW-1:0]                 op_word;
    logic signed [SAMPLE_BITS-1:0] op_x1;
    logic signed [SAMPLE_BITS-1:0] op_x2;
    logic signed [SAMPLE_BITS-1:0] op_y1;
    logic signed [SAMPLE_BITS-1:0] op_y2;
    logic signed [PW-1:0]          n_p_b0, n_p_b1, n_p_b2, n_p_a1, n_p_a2;
    logic signed [PW-1:0]          r_p_b0, r_p_b1, r_p_b2, r_p_a1, r_p_a2;
    logic                          r_b_chan;
    logic signed [SAMPLE_BITS-1:0] r_b_x0;
    logic signed [SAMPLE_BITS-1:0] r_b_x1;
    logic signed [SAMPLE_BITS-1:0] r_b_y1;
    logic signed [SAMPLE_BITS-1:0] c_y;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_a_x    <= i_sample_in;
            r_a_chan <= i_chan;
            r_a_ch   <= ch_in;
        end
    end

    always_comb begin
        if (r_w_valid && (r_w_ch == r_a_ch)) begin
            op_word = r_w_data;
        end else if (r_rd_vld) begin
            op_word = r_rd_data;
        end else begin
            op_word = '0;
        end
    end

    assign op_x1 = $signed(op_word[4*SAMPLE_BITS-1:3*SAMPLE_BITS]);
    assign op_x2 = $signed(op_word[3*SAMPLE_BITS-1:2*SAMPLE_BITS]);
    assign op_y1 = $signed(op_word[2*SAMPLE_BITS-1:SAMPLE_BITS]);
    assign op_y2 = $signed(op_word[SAMPLE_BITS-1:0]);

    assign n_p_b0 = PW'(r_coefs.b0) * PW'(r_a_x);
    assign n_p_b1 = PW'(r_coefs.b1) * PW'(op_x1);
    assign n_p_b2 = PW'(r_coefs.b2) * PW'(op_x2);
    assign n_p_a1 = PW'(r_coefs.a1) * PW'(op_y1);
    assign n_p_a2 = PW'(r_coefs.a2) * PW'(op_y2);

    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_p_b0   <= n_p_b0;
            r_p_b1   <= n_p_b1;
            r_p_b2   <= n_p_b2;
            r_p_a1   <= n_p_a1;
            r_p_a2   <= n_p_a2;
            r_b_ch   <= r_a_ch;
            r_b_chan <= r_a_chan;
            r_b_x0   <= r_a_x;
            r_b_x1   <= op_x1;
            r_b_y1   <= op_y1;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: sum, round, saturate, write back
    // ------------------------------------------------------------------
    mbq_mac #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_mac (
        .i_p_b0 (r_p_b0),
        .i_p_b1 (r_p_b1),
        .i_p_b2 (r_p_b2),
        .i_p_a1 (r_p_a1),
        .i_p_a2 (r_p_a2),
        .o_y    (c_y)
    );

    // shifted history: x1 <- x, x2 <- x1, y1 <- y, y2 <- y1
    assign wb_data = {r_b_x0, r_b_x1, c_y, r_b_y1};

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_w_ch   <= r_b_ch;
            r_w_data <= wb_data;
        end
    end

    // ------------------------------------------------------------------
    // Output queue
    // ------------------------------------------------------------------
    logic signed [SAMPLE_BITS-1:0] r_q_sample [OUT_DEPTH];
    logic                          r_q_chan   [OUT_DEPTH];
    logic [OUT_PTR_W-1:0]          r_wr_ptr;
    logic [OUT_PTR_W-1:0]          r_rd_ptr;
    logic [OUT_CNT_W-1:0]          r_q_cnt;

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_q_sample[r_wr_ptr] <= c_y;
            r_q_chan[r_wr_ptr]   <= r_b_chan;
        end
    end

    assign o_valid      = (r_q_cnt != '0);
    assign o_sample_out = r_q_sample[r_rd_ptr];
    assign o_out_chan   = r_q_chan[r_rd_ptr];

    // ------------------------------------------------------------------
    // Control state
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
            r_cnt      <= '0;
            r_hist_vld <= '0;
            r_w_valid  <= 1'b0;
            r_wr_ptr   <= '0;
            r_rd_ptr   <= '0;
            r_q_cnt    <= '0;
        end else begin
            r_a_valid <= acc;
            r_b_valid <= r_a_valid;
            r_cnt     <= n_cnt;
            if (r_b_valid) begin
                r_hist_vld[r_b_ch] <= 1'b1;
                r_w_valid          <= 1'b1;
                r_wr_ptr           <= r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_q_cnt <= r_q_cnt + OUT_CNT_W'(r_b_valid) - OUT_CNT_W'(pop);
        end
    end

`ifndef ASSERT_OFF
    // credit count matches what is really in flight
    a_credit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt == OUT_CNT_W'(r_a_valid) + OUT_CNT_W'(r_b_valid) + r_q_cnt)
        else $error("credit count out of step with pipeline and queue");

    // the queue never takes an item while full
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_b_valid && !pop) |-> (r_q_cnt < OUT_CNT_W'(OUT_DEPTH)))
        else $error("output queue overflow");

    // interlock: adjacent pipeline stages never hold the same channel
    a_interlock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_a_valid && r_b_valid) |-> (r_a_ch != r_b_ch))
        else $error("same channel in consecutive stages");

    // an accepted item passes stage A and reaches stage B, where it enters the queue
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc |=> ##1 r_b_valid)
        else $error("accepted item lost in pipeline");
`endif

endmodule

`default_nettype wire

@@ design/mbq_mac.sv @@
// Sum of the five products, round to nearest and saturate to the sample width.
`timescale 1ns / 1ps
`default_nettype none

module mbq_mac #(
    parameter int SAMPLE_BITS    = 24,
    parameter int COEF_FRAC_BITS = 29
) (
    input  wire logic signed [mbq_pkg::COEF_BITS+SAMPLE_BITS-1:0] i_p_b0,
    input  wire logic signed [mbq_pkg::COEF_BITS+SAMPLE_BITS-1:0] i_p_b1,
    input  wire logic signed [mbq_pkg::COEF_BITS+SAMPLE_BITS-1:0] i_p_b2,
    input  wire logic signed [mbq_pkg::COEF_BITS+SAMPLE_BITS-1:0] i_p_a1,
    input  wire logic signed [mbq_pkg::COEF_BITS+SAMPLE_BITS-1:0] i_p_a2,
    output logic      signed [SAMPLE_BITS-1:0]                    o_y
);
    import mbq_pkg::*;

    localparam int PW = COEF_BITS + SAMPLE_BITS;
    // three guard bits cover five terms
    localparam int SW = PW + 3;
    localparam logic signed [SW-1:0] ROUND_HALF = SW'(1) <<< (COEF_FRAC_BITS - 1);

    logic signed [SW-1:0] c_sum;
    logic signed [SW-1:0] c_rnd;
    logic signed [SW-1:0] c_q;
    logic                 c_ovf;

    assign c_sum = SW'(i_p_b0) + SW'(i_p_b1) + SW'(i_p_b2)
                 - SW'(i_p_a1) - SW'(i_p_a2);
    assign c_rnd = c_sum + ROUND_HALF;
    assign c_q   = c_rnd >>> COEF_FRAC_BITS;

    // fits when every bit above the sample sign bit copies it
    assign c_ovf = !((&c_q[SW-1:SAMPLE_BITS-1]) || !(|c_q[SW-1:SAMPLE_BITS-1]));

    always_comb begin
        if (!c_ovf) begin
            o_y = c_q[SAMPLE_BITS-1:0];
        end else if (c_q[SW-1]) begin
            o_y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            o_y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

endmodule

`default_nettype wire

@@ bench/tb_top.sv @@
// Self-checking testbench for the multichannel biquad IIR filter: directed and random items.
`timescale 1ns / 1ps

module tb_top;
    import mbq_pkg::*;

    // Block configuration under test
    localparam int CHANNELS       = 2;
    localparam int SAMPLE_BITS    = 24;
    localparam int COEF_FRAC_BITS = 29;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 9;
    localparam int RANDOM_ITEMS = 2000;
    // Cycles without any item, result or APB handshake before the run is abandoned.
    // Worst correct case is a long sender gap plus a long receiver stall.
    localparam int STALL_LIMIT  = 5000;
    // Result is offered once stage B has written it into the queue; allow generous slack at the end
    localparam int DRAIN_TAIL   = 16;

    // Register slots beyond the coefficient list (writes must be ignored)
    localparam int FIRST_SPARE_REG = NUM_REGS;
    localparam int ADDR_SLOTS      = 1 << (PADDR_W - 2);

    localparam longint SAMPLE_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
    localparam longint SAMPLE_MIN = -SAMPLE_MAX - 1;
    localparam longint Q_ONE      = longint'(1) << COEF_FRAC_BITS;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;

    // One filtered item as it should leave the block
    typedef struct packed {
        sample_t sample;
        logic    chan;
    } filt_result_t;

    localparam sample_t S_MAX    = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam sample_t S_MIN    = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    localparam coef_t   COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam coef_t   COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};

    // ------------------------------------------------------------------
    // DUT connections, all driven to known values from time zero
    // ------------------------------------------------------------------
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic                 o_ready;
    sample_t              i_sample_in = '0;
    logic                 i_chan      = 1'b0;
    logic                 o_valid;
    logic                 i_ready     = 1'b0;
    sample_t              o_sample_out;
    logic                 o_out_chan;
    logic                 psel        = 1'b0;
    logic                 penable     = 1'b0;
    logic                 pwrite      = 1'b0;
    logic [PADDR_W-1:0]   paddr       = '0;
    logic [PDATA_W-1:0]   pwdata      = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    multichannel_biquad_iir_filter #(
        .CHANNELS       (CHANNELS),
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_top (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_sample_in  (i_sample_in),
        .i_chan       (i_chan),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_sample_out (o_sample_out),
        .o_out_chan   (o_out_chan),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // ------------------------------------------------------------------
    // Filter predictor state: coefficients and per-channel history
    // ------------------------------------------------------------------
    coef_t   coef_regs [NUM_REGS];
    sample_t x_hist    [CHANNELS][2];   // [ch][0] = x1, [ch][1] = x2
    sample_t y_hist    [CHANNELS][2];   // [ch][0] = y1, [ch][1] = y2

    filt_result_t pending_outputs [$];  // filtered items still owed by the block
    int           fail_count  = 0;
    int           idle_cycles = 0;
    bit           tx_quiet    = 1'b0;   // sender runs without gaps
    bit           rx_quiet    = 1'b0;   // receiver runs without stalls

    // Clock: 4 ns high, 4 ns low
    always begin
        #(CLK_PERIOD / 2) i_clk = 1'b1;
        #(CLK_PERIOD / 2) i_clk = 1'b0;
    end

    // Exact sum of products, round to nearest with ties upward, saturate,
    // then shift the channel's history. Out-of-range channels fold onto the last.
    function automatic filt_result_t filter_sample(input sample_t x, input logic chan_field);
        int           ch;
        longint       acc;
        longint       y;
        filt_result_t res;
        ch  = (int'(chan_field) >= CHANNELS) ? CHANNELS - 1 : int'(chan_field);
        acc = longint'(coef_regs[REG_B0]) * longint'(x)
            + longint'(coef_regs[REG_B1]) * longint'(x_hist[ch][0])
            + longint'(coef_regs[REG_B2]) * longint'(x_hist[ch][1])
            - longint'(coef_regs[REG_A1]) * longint'(y_hist[ch][0])
            - longint'(coef_regs[REG_A2]) * longint'(y_hist[ch][1]);
        acc = acc + (longint'(1) << (COEF_FRAC_BITS - 1));
        y   = acc >>> COEF_FRAC_BITS;
        if (y > SAMPLE_MAX) y = SAMPLE_MAX;
        if (y < SAMPLE_MIN) y = SAMPLE_MIN;
        x_hist[ch][1] = x_hist[ch][0];
        x_hist[ch][0] = x;
        y_hist[ch][1] = y_hist[ch][0];
        y_hist[ch][0] = y[SAMPLE_BITS-1:0];
        res.sample = y[SAMPLE_BITS-1:0];
        res.chan   = chan_field;
        return res;
    endfunction

    // Mostly back-to-back, sometimes a few cycles, now and then a long gap
    function automatic int pick_gap(input bit quiet);
        int unsigned pick;
        if (quiet) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic sample_t random_sample();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return sample_t'($urandom);
        if (pick < 85) return sample_t'(int'($urandom_range(0, 512)) - 256);
        case ($urandom_range(0, 4))
            0: return S_MAX;
            1: return S_MIN;
            2: return sample_t'(0);
            3: return sample_t'(-1);
            default: return sample_t'(1);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers. All start and finish just after a falling edge.
    // ------------------------------------------------------------------

    // Offer one item, hold it until accepted, then record what it must produce
    task automatic push_sample(input sample_t x, input logic chan);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_sample_in <= x;
        i_chan      <= chan;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        pending_outputs.push_back(filter_sample(x, chan));
        @(negedge i_clk);
    endtask

    // Sender holds off until every owed result has come out
    task automatic wait_results_drained();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (pending_outputs.size() != 0) @(negedge i_clk);
    endtask

    task automatic apb_write(input int unsigned idx, input logic [PDATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx[PADDR_W-3:0], 2'b00};
        pwdata  <= data;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        // slots past the list are ignored by the block
        if (idx < NUM_REGS) coef_regs[idx] = data;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic check_coef_readback();
        t_reg_idx          r;
        logic [PDATA_W-1:0] got;
        for (int i = 0; i < NUM_REGS; i++) begin
            r = t_reg_idx'(i);
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            paddr   <= {r, 2'b00};
            @(negedge i_clk);
            penable <= 1'b1;
            @(posedge i_clk);
            while (!pready) @(posedge i_clk);
            got = prdata;
            @(negedge i_clk);
            psel    <= 1'b0;
            penable <= 1'b0;
            @(negedge i_clk);
            if (got !== coef_regs[r]) begin
                $error("prdata %s: expected %h, got %h", r.name(), coef_regs[r], got);
                fail_count++;
            end
        end
    endtask

    task automatic load_coefs(input coef_t b0, input coef_t b1, input coef_t b2,
                              input coef_t a1, input coef_t a2);
        apb_write(REG_B0, b0);
        apb_write(REG_B1, b1);
        apb_write(REG_B2, b2);
        apb_write(REG_A1, a1);
        apb_write(REG_A2, a2);
    endtask

    // One of: a stable design, raw random words, extremes, or small values
    task automatic program_random_coefs();
        coef_t  c [NUM_REGS];
        longint a2;
        longint lim;
        case ($urandom_range(0, 3))
            0: begin
                // |a2| < 1, |a1| < 1 + a2 keeps the poles inside the unit circle
                for (int i = 0; i < 3; i++)
                    c[i] = coef_t'(longint'($urandom_range(0, 32'h8000_0000)) - (Q_ONE << 1));
                a2  = longint'($urandom_range(0, 966367640)) - 483183820;
                lim = ((Q_ONE + a2) * 9) / 10;
                c[REG_A1] = coef_t'(longint'($urandom_range(0, int'(2 * lim))) - lim);
                c[REG_A2] = coef_t'(a2);
            end
            1: begin
                for (int i = 0; i < NUM_REGS; i++) c[i] = coef_t'($urandom);
            end
            2: begin
                for (int i = 0; i < NUM_REGS; i++)
                    case ($urandom_range(0, 3))
                        0: c[i] = COEF_MAX;
                        1: c[i] = COEF_MIN;
                        2: c[i] = coef_t'(0);
                        default: c[i] = coef_t'(Q_ONE);
                    endcase
            end
            default: begin
                for (int i = 0; i < NUM_REGS; i++)
                    c[i] = coef_t'(longint'($urandom_range(0, 32'h1000_0000)) - (Q_ONE >> 2));
            end
        endcase
        load_coefs(c[REG_B0], c[REG_B1], c[REG_B2], c[REG_A1], c[REG_A2]);
        check_coef_readback();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Reset leaves b0 = 1.0 and the rest zero: samples pass straight through
    task automatic test_reset_passthrough();
        check_coef_readback();
        push_sample(S_MAX, 1'b0);
        push_sample(S_MIN, 1'b1);
        push_sample(sample_t'(0), 1'b0);
        push_sample(sample_t'(-1), 1'b1);
        push_sample(sample_t'(1), 1'b0);
    endtask

    // Half-LSB results must round upward for both signs
    task automatic test_rounding_ties();
        wait_results_drained();
        load_coefs(coef_t'(Q_ONE / 2), '0, '0, '0, '0);
        push_sample(sample_t'(1), 1'b0);
        push_sample(sample_t'(-1), 1'b1);
        push_sample(sample_t'(3), 1'b0);
        push_sample(sample_t'(-3), 1'b1);
        wait_results_drained();
        load_coefs(coef_t'(-Q_ONE / 2), '0, '0, '0, '0);
        push_sample(sample_t'(1), 1'b0);
        push_sample(sample_t'(-1), 1'b1);
    endtask

    // Largest gains in both signs drive the output into both rails
    task automatic test_saturation();
        wait_results_drained();
        load_coefs(COEF_MAX, '0, '0, '0, '0);
        push_sample(S_MAX, 1'b0);
        push_sample(S_MIN, 1'b1);
        wait_results_drained();
        load_coefs(COEF_MIN, '0, '0, '0, '0);
        push_sample(S_MIN, 1'b0);
        push_sample(S_MAX, 1'b1);
    endtask

    // All five taps live; channels interleaved and back-to-back on one channel
    task automatic test_history_per_channel();
        wait_results_drained();
        load_coefs(coef_t'(Q_ONE / 2), coef_t'(Q_ONE / 4), coef_t'(-Q_ONE / 8),
                   coef_t'(-Q_ONE / 2), coef_t'(Q_ONE / 4));
        push_sample(sample_t'(1000), 1'b0);
        push_sample(sample_t'(-2000), 1'b1);
        push_sample(sample_t'(3000), 1'b0);
        push_sample(sample_t'(-4000), 1'b0);
        push_sample(sample_t'(5000), 1'b1);
        push_sample(sample_t'(0), 1'b0);
    endtask

    // Writes to addresses past the list must leave every coefficient alone
    task automatic test_spare_registers();
        wait_results_drained();
        for (int idx = FIRST_SPARE_REG; idx < ADDR_SLOTS; idx++)
            apb_write(idx, $urandom);
        check_coef_readback();
        push_sample(random_sample(), 1'b0);
        push_sample(random_sample(), 1'b1);
    endtask

    // Blocks of random items, each under a fresh coefficient set and idling mix
    task automatic test_random_streams(input int n_items);
        int          sent;
        int          n;
        int unsigned chan_mode;
        logic        ch;
        sent = 0;
        ch   = 1'b0;
        while (sent < n_items) begin
            wait_results_drained();
            program_random_coefs();
            tx_quiet  = ($urandom_range(0, 3) == 0);
            rx_quiet  = ($urandom_range(0, 3) == 0);
            chan_mode = $urandom_range(0, 2);
            n = $urandom_range(150, 300);
            for (int i = 0; i < n; i++) begin
                case (chan_mode)
                    0: ch = 1'($urandom_range(0, 1));
                    1: ch = ~ch;
                    default: if ($urandom_range(0, 7) == 0) ch = ~ch;
                endcase
                // mid-block hold-off until the pipeline is empty
                if (i == n / 2) wait_results_drained();
                push_sample(random_sample(), ch);
            end
            sent += n;
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result receiver: ready in runs, with random stalls between them
    // ------------------------------------------------------------------
    initial begin : result_sink
        int gap;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge i_clk);
            gap = pick_gap(rx_quiet);
            if (gap > 0) begin
                i_ready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
    end

    // Compare every accepted result with the oldest owed item
    always @(posedge i_clk) begin : output_check
        filt_result_t want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_outputs.size() == 0) begin
                $error("result with nothing owed: sample_out %0d, out_chan %0d",
                       $signed(o_sample_out), o_out_chan);
                fail_count++;
            end else begin
                want = pending_outputs.pop_front();
                if (o_sample_out !== want.sample) begin
                    $error("sample_out mismatch: expected %0d, got %0d",
                           $signed(want.sample), $signed(o_sample_out));
                    fail_count++;
                end
                if (o_out_chan !== want.chan) begin
                    $error("out_chan mismatch: expected %0d, got %0d",
                           want.chan, o_out_chan);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: too long with no handshake on any port ends the run
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || (psel && penable)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("multichannel_biquad_iir_filter verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        for (int i = 0; i < NUM_REGS; i++) coef_regs[i] = '0;
        coef_regs[REG_B0] = coef_t'(Q_ONE);
        for (int c = 0; c < CHANNELS; c++) begin
            x_hist[c][0] = '0;
            x_hist[c][1] = '0;
            y_hist[c][0] = '0;
            y_hist[c][1] = '0;
        end

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_passthrough();
        test_rounding_ties();
        test_saturation();
        test_history_per_channel();
        test_spare_registers();
        test_random_streams(RANDOM_ITEMS);

        wait_results_drained();
        repeat (DRAIN_TAIL) @(negedge i_clk);
        if (fail_count == 0 && pending_outputs.size() == 0) begin
            $display("multichannel_biquad_iir_filter verification clean");
        end else begin
            $display("multichannel_biquad_iir_filter verification failed");
        end
        $finish;
    end

endmodule

@@ files.f @@
design/mbq_pkg.sv
design/mbq_mac.sv
design/multichannel_biquad_iir_filter.sv
bench/tb_top.sv
